>>> rtl/tlse_pkg.sv
`timescale 1ns / 1ps

package tlse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 17;
  localparam int VAL_W     = 21;
  localparam int DEG_W     = 2;
  localparam int IDX_W     = 3;
  localparam int ORD_W     = 2;

  // basis value width: one - x - y over the whole input range
  localparam int PH_W   = IN_W + 2;
  localparam int OP_W   = PH_W + 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int WIDE_W = PROD_W + 2;

  localparam logic [DEG_W-1:0] DEG_LIN  = 2'd1;
  localparam logic [DEG_W-1:0] DEG_QUAD = 2'd2;

  localparam logic [IDX_W-1:0] N_LIN  = 3'd3;
  localparam logic [IDX_W-1:0] N_QUAD = 3'd6;

  typedef logic [2*ORD_W-1:0] der_t;

  localparam der_t DER_VAL = 4'b0000;
  localparam der_t DER_X   = 4'b0100;
  localparam der_t DER_Y   = 4'b0001;
  localparam der_t DER_XY  = 4'b0101;
  localparam der_t DER_XX  = 4'b1000;
  localparam der_t DER_YY  = 4'b0010;

  typedef struct packed {
    logic [IN_W-1:0]  point_x;
    logic [IN_W-1:0]  point_y;
    logic [DEG_W-1:0] degree;
    logic [IDX_W-1:0] basis_index;
    logic [ORD_W-1:0] x_order;
    logic [ORD_W-1:0] y_order;
  } tlse_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    invalid;
  } tlse_res_t;

endpackage

>>> rtl/triangle_lagrange_shape_eval_top.sv
`timescale 1ns / 1ps

// Lagrange shape function evaluator for the reference triangle, degree 1 and 2,
// with partial derivatives up to first order (degree 1) and second order
// (degree 2). Takes one beat per cycle while the output is not stalled; each
// beat goes through the input register, then one pass through a single signed
// multiplier with rounding and saturation, then the output register. Coordinates are
// unsigned with 16 fraction bits, the value is signed with 16 fraction bits,
// rounded half up and saturated to 21 bits. An unsupported degree or shape
// index returns zero with invalid set; uncovered derivative orders return zero.
module triangle_lagrange_shape_eval_top import tlse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IN_W-1:0]         in_point_x,
  input  logic [IN_W-1:0]         in_point_y,
  input  logic [DEG_W-1:0]        in_degree,
  input  logic [IDX_W-1:0]        in_basis_index,
  input  logic [ORD_W-1:0]        in_x_order,
  input  logic [ORD_W-1:0]        in_y_order,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_invalid
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  tlse_item_t s1_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  tlse_res_t  out_res_r;
  tlse_res_t  res;
  logic       adv;
  logic       in_fire;

  assign adv     = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.point_x     <= in_point_x;
      s1_item_r.point_y     <= in_point_y;
      s1_item_r.degree      <= in_degree;
      s1_item_r.basis_index <= in_basis_index;
      s1_item_r.x_order     <= in_x_order;
      s1_item_r.y_order     <= in_y_order;
    end
    if (adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  tlse_eval u_eval (
    .item (s1_item_r),
    .res  (res)
  );

  assign out_valid   = out_valid_r;
  assign out_value   = out_res_r.value;
  assign out_invalid = out_res_r.invalid;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.invalid |-> out_res_r.value == '0)
    else $error("invalid result with nonzero value");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("stage beat lost on advance");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled stage changed");

endmodule

>>> rtl/tlse_eval.sv
`timescale 1ns / 1ps

module tlse_eval import tlse_pkg::*; (
  input  tlse_item_t item,
  output tlse_res_t  res
);

  localparam logic signed [WIDE_W-1:0] ONE_W  = WIDE_W'(1) <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [OP_W-1:0]   ONE_OP = OP_W'(1) <<< FRAC_BITS;
  localparam logic signed [PH_W-1:0]   ONE_PH = PH_W'(1) <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (VAL_W - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -(WIDE_W'(1) <<< (VAL_W - 1));

  logic signed [PH_W-1:0]   ph [3];
  logic signed [WIDE_W-1:0] wph [3];
  logic [1:0]               ia;
  logic [1:0]               ib;
  logic                     quad_pair;
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [WIDE_W-1:0] prod_q;
  logic signed [WIDE_W-1:0] rnd;
  logic signed [WIDE_W-1:0] p4;
  logic signed [WIDE_W-1:0] lin;
  logic signed [WIDE_W-1:0] v;
  logic                     use_mul;
  logic                     bad;
  der_t                     der;

  // operand selection and the single multiplier
  always_comb begin
    ph[0] = ONE_PH - signed'({{(PH_W-IN_W){1'b0}}, item.point_x})
                   - signed'({{(PH_W-IN_W){1'b0}}, item.point_y});
    ph[1] = signed'({{(PH_W-IN_W){1'b0}}, item.point_x});
    ph[2] = signed'({{(PH_W-IN_W){1'b0}}, item.point_y});
    for (int i = 0; i < 3; i++) begin
      wph[i] = WIDE_W'(ph[i]);
    end
    quad_pair = (item.basis_index >= N_LIN);
    case (item.basis_index)
      3'd3:    begin ia = 2'd0; ib = 2'd1; end
      3'd4:    begin ia = 2'd1; ib = 2'd2; end
      3'd5:    begin ia = 2'd0; ib = 2'd2; end
      3'd0:    begin ia = 2'd0; ib = 2'd0; end
      3'd1:    begin ia = 2'd1; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd2; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
    mul_a  = OP_W'(ph[ia]);
    mul_b  = quad_pair ? OP_W'(ph[ib]) : ((OP_W'(ph[ia]) <<< 1) - ONE_OP);
    prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_q = quad_pair ? (WIDE_W'(prod) <<< 2) : WIDE_W'(prod);
    rnd    = (prod_q + HALF_W) >>> FRAC_BITS;
    p4     = (wph[ia] <<< 2) - ONE_W;
  end

  // exact terms per degree, index and derivative
  always_comb begin
    der     = {item.x_order, item.y_order};
    lin     = '0;
    use_mul = 1'b0;
    bad     = 1'b0;
    case (item.degree)
      DEG_LIN: begin
        if (item.basis_index >= N_LIN) begin
          bad = 1'b1;
        end else begin
          case (der)
            DER_VAL: lin = wph[ia];
            DER_X: begin
              if (item.basis_index == 3'd0) lin = -ONE_W;
              else if (item.basis_index == 3'd1) lin = ONE_W;
            end
            DER_Y: begin
              if (item.basis_index == 3'd0) lin = -ONE_W;
              else if (item.basis_index == 3'd2) lin = ONE_W;
            end
            default: lin = '0;
          endcase
        end
      end
      DEG_QUAD: begin
        if (item.basis_index >= N_QUAD) begin
          bad = 1'b1;
        end else if (!quad_pair) begin
          case (der)
            DER_VAL: use_mul = 1'b1;
            DER_X: begin
              if (item.basis_index == 3'd0) lin = -p4;
              else if (item.basis_index == 3'd1) lin = p4;
            end
            DER_Y: begin
              if (item.basis_index == 3'd0) lin = -p4;
              else if (item.basis_index == 3'd2) lin = p4;
            end
            DER_XY: begin
              if (item.basis_index == 3'd0) lin = ONE_W <<< 2;
            end
            DER_XX: begin
              if (item.basis_index != 3'd2) lin = ONE_W <<< 2;
            end
            DER_YY: begin
              if (item.basis_index != 3'd1) lin = ONE_W <<< 2;
            end
            default: lin = '0;
          endcase
        end else begin
          case (der)
            DER_VAL: use_mul = 1'b1;
            DER_X: begin
              case (item.basis_index)
                3'd3:    lin = (wph[0] - wph[1]) <<< 2;
                3'd4:    lin = wph[2] <<< 2;
                default: lin = -(wph[2] <<< 2);
              endcase
            end
            DER_Y: begin
              case (item.basis_index)
                3'd3:    lin = -(wph[1] <<< 2);
                3'd4:    lin = wph[1] <<< 2;
                default: lin = (wph[0] - wph[2]) <<< 2;
              endcase
            end
            DER_XY: begin
              if (item.basis_index == 3'd4) lin = ONE_W <<< 2;
              else lin = -(ONE_W <<< 2);
            end
            DER_XX: begin
              if (item.basis_index == 3'd3) lin = -(ONE_W <<< 3);
            end
            DER_YY: begin
              if (item.basis_index == 3'd5) lin = -(ONE_W <<< 3);
            end
            default: lin = '0;
          endcase
        end
      end
      default: bad = 1'b1;
    endcase
  end

  // select, clear on invalid, saturate
  always_comb begin
    if (bad) v = '0;
    else if (use_mul) v = rnd;
    else v = lin;
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    res.value   = v[VAL_W-1:0];
    res.invalid = bad;
  end

endmodule

>>> tb/sv/tb_triangle_lagrange_shape_eval_top.sv
`timescale 1ns / 1ps

module tb_triangle_lagrange_shape_eval_top;
  import tlse_pkg::*;

  localparam longint ONE_Q   = longint'(1) <<< FRAC_BITS;
  localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));

  localparam logic [DEG_W-1:0] DEG_NONE = 2'd0;
  localparam logic [DEG_W-1:0] DEG_HIGH = 2'd3;
  localparam der_t             DER_HIGH = 4'b1111;

  localparam int N_PHASES        = 4;
  localparam int ITEMS_PER_PHASE = 382;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [IN_W-1:0]         in_point_x = '0;
  logic [IN_W-1:0]         in_point_y = '0;
  logic [DEG_W-1:0]        in_degree = '0;
  logic [IDX_W-1:0]        in_basis_index = '0;
  logic [ORD_W-1:0]        in_x_order = '0;
  logic [ORD_W-1:0]        in_y_order = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_invalid;

  tlse_item_t eval_q[$];
  tlse_res_t  shape_want_q[$];
  tlse_item_t next_item;
  tlse_item_t taken_item;
  tlse_res_t  want;
  logic       in_took = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count = 0;

  triangle_lagrange_shape_eval_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_degree      (in_degree),
    .in_basis_index (in_basis_index),
    .in_x_order     (in_x_order),
    .in_y_order     (in_y_order),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_invalid    (out_invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint slope_x(int i);
    case (i)
      0: return -1;
      1: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint slope_y(int i);
    case (i)
      0: return -1;
      2: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint round_half_up(longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic tlse_res_t shape_value(tlse_item_t it);
    longint    ph [3];
    longint    p, gx, gy, v;
    int        a, b, k;
    der_t      der;
    logic      bad;
    tlse_res_t r;
    ph[1] = longint'(it.point_x);
    ph[2] = longint'(it.point_y);
    ph[0] = ONE_Q - ph[1] - ph[2];
    der = {it.x_order, it.y_order};
    k = int'(it.basis_index);
    v = 0;
    bad = 1'b0;
    if (it.degree == DEG_LIN) begin
      if (it.basis_index >= N_LIN) begin
        bad = 1'b1;
      end else begin
        case (der)
          DER_VAL: v = ph[k];
          DER_X:   v = slope_x(k) * ONE_Q;
          DER_Y:   v = slope_y(k) * ONE_Q;
          default: v = 0;
        endcase
      end
    end else if (it.degree == DEG_QUAD) begin
      if (it.basis_index >= N_QUAD) begin
        bad = 1'b1;
      end else if (it.basis_index < N_LIN) begin
        p  = ph[k];
        gx = slope_x(k);
        gy = slope_y(k);
        case (der)
          DER_VAL: v = round_half_up(p * (2 * p - ONE_Q));
          DER_X:   v = gx * (4 * p - ONE_Q);
          DER_Y:   v = gy * (4 * p - ONE_Q);
          DER_XY:  v = 4 * gx * gy * ONE_Q;
          DER_XX:  v = 4 * gx * gx * ONE_Q;
          DER_YY:  v = 4 * gy * gy * ONE_Q;
          default: v = 0;
        endcase
      end else begin
        // edge midpoints: (0,1), (1,2), (0,2)
        a = (k == 4) ? 1 : 0;
        b = (k == 3) ? 1 : 2;
        case (der)
          DER_VAL: v = round_half_up(4 * ph[a] * ph[b]);
          DER_X:   v = 4 * (slope_x(a) * ph[b] + ph[a] * slope_x(b));
          DER_Y:   v = 4 * (slope_y(a) * ph[b] + ph[a] * slope_y(b));
          DER_XY:  v = 4 * (slope_x(a) * slope_y(b) + slope_y(a) * slope_x(b)) * ONE_Q;
          DER_XX:  v = 8 * slope_x(a) * slope_x(b) * ONE_Q;
          DER_YY:  v = 8 * slope_y(a) * slope_y(b) * ONE_Q;
          default: v = 0;
        endcase
      end
    end else begin
      bad = 1'b1;
    end
    if (bad) v = 0;
    if (v > VAL_MAX) v = VAL_MAX;
    else if (v < VAL_MIN) v = VAL_MIN;
    r.value   = v[VAL_W-1:0];
    r.invalid = bad;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    mismatch_count++;
  endtask

  task automatic add_item(input int x, input int y, input logic [DEG_W-1:0] d,
                          input int idx, input der_t der);
    tlse_item_t it;
    it.point_x     = x[IN_W-1:0];
    it.point_y     = y[IN_W-1:0];
    it.degree      = d;
    it.basis_index = idx[IDX_W-1:0];
    it.x_order     = der[2*ORD_W-1:ORD_W];
    it.y_order     = der[ORD_W-1:0];
    eval_q.push_back(it);
  endtask

  // input driver and ready generator
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!in_valid || in_took) begin
      if (eval_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = eval_q.pop_front();
        in_valid       <= 1'b1;
        in_point_x     <= next_item.point_x;
        in_point_y     <= next_item.point_y;
        in_degree      <= next_item.degree;
        in_basis_index <= next_item.basis_index;
        in_x_order     <= next_item.x_order;
        in_y_order     <= next_item.y_order;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted beats on both sides
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken_item.point_x     = in_point_x;
        taken_item.point_y     = in_point_y;
        taken_item.degree      = in_degree;
        taken_item.basis_index = in_basis_index;
        taken_item.x_order     = in_x_order;
        taken_item.y_order     = in_y_order;
        shape_want_q.push_back(shape_value(taken_item));
      end
      if (out_valid && out_ready) begin
        if (shape_want_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", longint'(out_value),
                          longint'(0));
        end else begin
          want = shape_want_q.pop_front();
          if (out_value !== want.value)
            report_mismatch("value", longint'(out_value), longint'(want.value));
          if (out_invalid !== want.invalid)
            report_mismatch("invalid", longint'(out_invalid), longint'(want.invalid));
        end
      end
    end
  end

  initial begin : stim
    int   send_tab [N_PHASES];
    int   recv_tab [N_PHASES];
    int   ph_i, n, r, rx, ry, idx;
    logic [DEG_W-1:0] d;
    der_t der;
    send_tab = '{0, 48, 0, 7};
    recv_tab = '{0, 0, 48, 7};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_item(0, 0, DEG_LIN, 0, DER_VAL);
    add_item(65536, 0, DEG_LIN, 1, DER_VAL);
    add_item(0, 65536, DEG_LIN, 2, DER_VAL);
    add_item(65536, 65536, DEG_LIN, 0, DER_VAL);
    add_item(1000, 2000, DEG_LIN, 0, DER_X);
    add_item(1000, 2000, DEG_LIN, 2, DER_Y);
    add_item(1000, 2000, DEG_LIN, 1, DER_XY);
    add_item(21845, 21845, DEG_QUAD, 0, DER_VAL);
    // rounding ties, negative then positive
    add_item(128, 0, DEG_QUAD, 1, DER_VAL);
    add_item(128, 65344, DEG_QUAD, 3, DER_VAL);
    add_item(30000, 10000, DEG_QUAD, 4, DER_VAL);
    add_item(30000, 10000, DEG_QUAD, 5, DER_X);
    add_item(30000, 10000, DEG_QUAD, 3, DER_Y);
    add_item(0, 0, DEG_QUAD, 0, DER_XY);
    add_item(0, 0, DEG_QUAD, 3, DER_XX);
    add_item(0, 0, DEG_QUAD, 5, DER_YY);
    add_item(0, 0, DEG_QUAD, 2, DER_HIGH);
    // saturation at both ends
    add_item(131071, 131071, DEG_QUAD, 0, DER_VAL);
    add_item(131071, 131071, DEG_QUAD, 3, DER_X);
    add_item(131071, 131071, DEG_QUAD, 4, DER_VAL);
    add_item(500, 500, DEG_NONE, 0, DER_VAL);
    add_item(500, 500, DEG_HIGH, 1, DER_X);
    add_item(500, 500, DEG_LIN, 3, DER_VAL);
    add_item(500, 500, DEG_QUAD, 6, DER_XY);
    add_item(500, 500, DEG_QUAD, 7, DER_XX);

    for (ph_i = 0; ph_i < N_PHASES; ph_i++) begin
      while (eval_q.size() > 0 || in_valid) @(posedge clk);
      // sender holds off until every pending result is out
      while (shape_want_q.size() > 0) @(posedge clk);
      repeat (4) @(posedge clk);
      send_idle_pct  = send_tab[ph_i];
      recv_stall_pct = recv_tab[ph_i];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rx = $urandom_range(0, 65536);
          ry = $urandom_range(0, 65536 - rx);
        end else if (r < 85) begin
          rx = $urandom_range(0, 65536);
          ry = $urandom_range(0, 65536);
        end else begin
          rx = $urandom_range(0, 131071);
          ry = $urandom_range(0, 131071);
        end
        r = $urandom_range(0, 99);
        if (r < 45) d = DEG_QUAD;
        else if (r < 80) d = DEG_LIN;
        else d = DEG_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 7);
        else if (d == DEG_QUAD) idx = $urandom_range(0, 5);
        else idx = $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
          der = der_t'($urandom_range(0, 15));
        end else begin
          case ($urandom_range(0, 5))
            0: der = DER_VAL;
            1: der = DER_X;
            2: der = DER_Y;
            3: der = DER_XY;
            4: der = DER_XX;
            default: der = DER_YY;
          endcase
        end
        add_item(rx, ry, d, idx, der);
      end
    end

    while (eval_q.size() > 0 || in_valid) @(posedge clk);
    while (shape_want_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_triangle_lagrange_shape_eval_top: clean");
    end else begin
      $display("tb_triangle_lagrange_shape_eval_top: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_triangle_lagrange_shape_eval_top: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/tlse_pkg.sv
rtl/tlse_eval.sv
rtl/triangle_lagrange_shape_eval_top.sv
tb/sv/tb_triangle_lagrange_shape_eval_top.sv
